// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/kclc_pkg.sv =====
// ----------------------------------------------------------------------------
// kclc_pkg
// Types and constants shared by the keypad code lock checker.
// ----------------------------------------------------------------------------
package kclc_pkg;

  localparam int unsigned CODE_W    = 24;  // six bcd nibbles per code
  localparam int unsigned NUM_NIBS  = 6;
  localparam int unsigned NUM_USERS = 3;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned KEY_W     = 5;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;

  // key codes
  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 5'd9;
  localparam logic [KEY_W-1:0] KEY_BACK_A    = 5'd11;
  localparam logic [KEY_W-1:0] KEY_BACK_B    = 5'd12;
  localparam logic [KEY_W-1:0] KEY_QUIT_A    = 5'd13;
  localparam logic [KEY_W-1:0] KEY_QUIT_B    = 5'd14;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VD_WRONG  = 3'd0;
  localparam logic [VERDICT_W-1:0] VD_ROOT   = 3'd1;
  localparam logic [VERDICT_W-1:0] VD_USER_A = 3'd2;
  localparam logic [VERDICT_W-1:0] VD_USER_B = 3'd3;
  localparam logic [VERDICT_W-1:0] VD_USER_C = 3'd4;

  // register indexes on the apb port
  typedef enum logic [2:0] {
    REG_ROOT_CODE   = 3'd0,
    REG_USER_CODE_A = 3'd1,
    REG_USER_CODE_B = 3'd2,
    REG_USER_CODE_C = 3'd3,
    REG_USER_MASK   = 3'd4,
    REG_USERS_EN    = 3'd5
  } reg_idx_e;

  // event reported for each key
  typedef enum logic [2:0] {
    EV_STORED  = 3'd0,
    EV_REMOVED = 3'd1,
    EV_IGNORED = 3'd2,
    EV_VERDICT = 3'd3,
    EV_ABORTED = 3'd4
  } event_e;

  typedef struct packed {
    logic [CODE_W-1:0]                    root_code;
    logic [NUM_USERS-1:0][CODE_W-1:0]     user_code;
    logic [NUM_USERS-1:0]                 user_valid_mask;
    logic                                 users_enabled;
  } cfg_t;

  typedef struct packed {
    event_e                 event_res;
    logic [COUNT_W-1:0]     position;
    logic [DIGIT_W-1:0]     digit;
    logic [VERDICT_W-1:0]   verdict;
  } res_t;

endpackage

// ===== src/kclc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kclc_cfg_regs
// APB register file holding the root code, user codes and user controls.
// ----------------------------------------------------------------------------
module kclc_cfg_regs import kclc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.root_code       <= '0;
      cfg_q.user_code       <= '0;
      cfg_q.user_valid_mask <= '0;
      cfg_q.users_enabled   <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROOT_CODE:   cfg_q.root_code       <= pwdata[CODE_W-1:0];
        REG_USER_CODE_A: cfg_q.user_code[0]    <= pwdata[CODE_W-1:0];
        REG_USER_CODE_B: cfg_q.user_code[1]    <= pwdata[CODE_W-1:0];
        REG_USER_CODE_C: cfg_q.user_code[2]    <= pwdata[CODE_W-1:0];
        REG_USER_MASK:   cfg_q.user_valid_mask <= pwdata[NUM_USERS-1:0];
        REG_USERS_EN:    cfg_q.users_enabled   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ROOT_CODE:   prdata = APB_DW'(cfg_q.root_code);
      REG_USER_CODE_A: prdata = APB_DW'(cfg_q.user_code[0]);
      REG_USER_CODE_B: prdata = APB_DW'(cfg_q.user_code[1]);
      REG_USER_CODE_C: prdata = APB_DW'(cfg_q.user_code[2]);
      REG_USER_MASK:   prdata = APB_DW'(cfg_q.user_valid_mask);
      REG_USERS_EN:    prdata = APB_DW'(cfg_q.users_enabled);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/kclc_judge.sv =====
// ----------------------------------------------------------------------------
// kclc_judge
// Compares a full entry against the root and user codes in parallel and
// picks the verdict by priority.
// ----------------------------------------------------------------------------
module kclc_judge import kclc_pkg::*; #(
  parameter int unsigned CODE_DIGITS = 6
) (
  input  logic [CODE_DIGITS-1:0][DIGIT_W-1:0] entry_i,
  input  cfg_t                                cfg_i,
  output logic [VERDICT_W-1:0]                verdict_o
);

  logic                 root_hit;
  logic [NUM_USERS-1:0] user_hit;

  // digit i of the entry against the i-th nibble from the top of each code
  always_comb begin
    root_hit = 1'b1;
    user_hit = '1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (entry_i[i] != cfg_i.root_code[CODE_W-1-DIGIT_W*i -: DIGIT_W]) begin
        root_hit = 1'b0;
      end
      for (int s = 0; s < NUM_USERS; s++) begin
        if (entry_i[i] != cfg_i.user_code[s][CODE_W-1-DIGIT_W*i -: DIGIT_W]) begin
          user_hit[s] = 1'b0;
        end
      end
    end
    user_hit = user_hit & cfg_i.user_valid_mask & {NUM_USERS{cfg_i.users_enabled}};
  end

  // root first, then lower user slots
  always_comb begin
    priority if (root_hit) begin
      verdict_o = VD_ROOT;
    end else if (user_hit[0]) begin
      verdict_o = VD_USER_A;
    end else if (user_hit[1]) begin
      verdict_o = VD_USER_B;
    end else if (user_hit[2]) begin
      verdict_o = VD_USER_C;
    end else begin
      verdict_o = VD_WRONG;
    end
  end

endmodule

// ===== src/kclc_entry.sv =====
// ----------------------------------------------------------------------------
// kclc_entry
// Entry buffer and digit count; decodes one key and forms its result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kclc_entry import kclc_pkg::*; #(
  parameter int unsigned CODE_DIGITS = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [KEY_W-1:0] key_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  logic [CODE_DIGITS-1:0][DIGIT_W-1:0] digits_q;
  logic [CODE_DIGITS-1:0][DIGIT_W-1:0] cand;
  logic [COUNT_W-1:0]                  count_q, count_d;
  logic [VERDICT_W-1:0]                judge_verdict;
  logic                                is_digit;
  logic                                last_digit;

  assign is_digit   = (key_i <= KEY_DIGIT_MAX);
  assign last_digit = (count_q == COUNT_W'(CODE_DIGITS - 1));

  // buffer as it stands with this key placed at the current position
  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      cand[i] = (count_q == COUNT_W'(i)) ? key_i[DIGIT_W-1:0] : digits_q[i];
    end
  end

  kclc_judge #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_judge (
    .entry_i   (cand),
    .cfg_i     (cfg_i),
    .verdict_o (judge_verdict)
  );

  // key decode
  always_comb begin
    count_d           = count_q;
    res_o.event_res   = EV_IGNORED;
    res_o.digit       = '0;
    res_o.verdict     = VD_WRONG;
    priority if (is_digit) begin
      res_o.digit = key_i[DIGIT_W-1:0];
      if (last_digit) begin
        count_d         = '0;
        res_o.event_res = EV_VERDICT;
        res_o.verdict   = judge_verdict;
      end else begin
        count_d         = count_q + COUNT_W'(1);
        res_o.event_res = EV_STORED;
      end
    end else if (key_i == KEY_BACK_A || key_i == KEY_BACK_B) begin
      if (count_q != '0) begin
        count_d         = count_q - COUNT_W'(1);
        res_o.event_res = EV_REMOVED;
      end
    end else if (key_i == KEY_QUIT_A || key_i == KEY_QUIT_B) begin
      count_d         = '0;
      res_o.event_res = EV_ABORTED;
    end else begin
      count_d = count_q;
    end
    res_o.position = count_d;
  end

  // digit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

  // entry digits, written at the current position
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (fire_i && is_digit && count_q == COUNT_W'(i)) begin
        digits_q[i] <= key_i[DIGIT_W-1:0];
      end
    end
  end

  `ASSERT_HOLDS(a_count_in_range, clk_i, rst_ni, count_q < COUNT_W'(CODE_DIGITS), "entry count out of range")
  `ASSERT_HOLDS(a_verdict_clears, clk_i, rst_ni, fire_i && res_o.event_res == EV_VERDICT |=> count_q == '0, "buffer not emptied after verdict")

endmodule

// ===== src/keypad_code_lock_checker.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock_checker
// Keypad code lock: buffers digits and judges a full entry against the
// root code and up to three user codes.
// ----------------------------------------------------------------------------
// One key code enters per item and gives exactly one result item. The block
// takes one item every clock cycle while the output is not stalled; each item
// passes through the input register, where decode, buffer update and the four
// parallel code compares happen, and then the result register, from which its
// result is presented. Stall on the output backs up through both registers;
// with the output free, the input never stalls. The user must write codes
// over the APB port only while no item is in flight; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keypad_code_lock_checker import kclc_pkg::*; #(
  parameter int unsigned CODE_DIGITS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready,
  // key items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KEY_W-1:0]     key_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           event_res_o,
  output logic [COUNT_W-1:0]   position_o,
  output logic [DIGIT_W-1:0]   digit_o,
  output logic [VERDICT_W-1:0] verdict_o
);

  cfg_t             cfg;
  res_t             res, res_q;
  logic             in_valid_q, out_valid_q;
  logic [KEY_W-1:0] key_q;
  logic             advance, fire;

  kclc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline handshake
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      key_q <= key_i;
    end
  end

  kclc_entry #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_entry (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .key_i  (key_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = res_q.event_res;
  assign position_o  = res_q.position;
  assign digit_o     = res_q.digit;
  assign verdict_o   = res_q.verdict;

  `ASSERT_HOLDS(a_stall_cause, clk_i, rst_ni, in_stall_o |-> in_valid_q && out_valid_q && out_stall_i, "input stalled without a blocked result")
  `ASSERT_HOLDS(a_verdict_event, clk_i, rst_ni, out_valid_o && verdict_o != VD_WRONG |-> event_res_o == EV_VERDICT, "verdict set outside a verdict event")

endmodule
